/* rtl/pnm_ascii_number_tokenizer_macros.svh */
// Assertion macros for the tokenizer RTL.
// Included by pnm_tok_core, the module that carries concurrent checks; no other dependencies.
`ifndef PNM_ASCII_NUMBER_TOKENIZER_MACROS_SVH
`define PNM_ASCII_NUMBER_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define PNM_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tokenizer assertion failed");
// Clocked check that also holds during reset.
`define PNM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tokenizer assertion failed");
`else
`define PNM_ASSERT_RST(lbl, clk, rst_n, prop)
`define PNM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/pnm_tok_pkg.sv */
// Package for the tokenizer: widths, character codes and the result struct.
// No dependencies; imported by every tokenizer module.
`default_nettype none
package pnm_tok_pkg;

  localparam int VALUE_BITS = 32;  // accumulator width, saturates at 2^VALUE_BITS-1
  localparam int OUT_BITS   = 32;  // width of the emitted number field
  localparam int CHAR_BITS  = 8;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  localparam logic [CHAR_BITS-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_BITS-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic                valid;
    logic [OUT_BITS-1:0] value;
    logic                present;
    logic                garbage;
    logic                ovf;
    logic                last;
  } tok_res_t;

  // Fit the accumulator into the output field: truncate or zero-extend.
  function automatic logic [OUT_BITS-1:0] to_out(input logic [VALUE_BITS-1:0] acc);
    logic [VALUE_BITS+OUT_BITS-1:0] wide;
    wide = {{OUT_BITS{1'b0}}, acc};
    return wide[OUT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/pnm_tok_core.sv */
// Tokenizer state machine: classifies one byte per transfer and updates state.
// Depends on pnm_tok_pkg and the assertion macro header.
`default_nettype none
`include "pnm_ascii_number_tokenizer_macros.svh"
module pnm_tok_core
  import pnm_tok_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire logic                 step,
  input  wire logic [CHAR_BITS-1:0] char_byte,
  input  wire logic                 stream_end,
  output tok_res_t                  res
);

  localparam logic [1:0] PH_SKIP    = 2'd0;
  localparam logic [1:0] PH_COMMENT = 2'd1;
  localparam logic [1:0] PH_NUMBER  = 2'd2;

  logic                  mode_r;
  logic [1:0]            phase_r, phase_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  sat_r, sat_nxt;
  logic                  garbage_r, garbage_nxt;

  logic                  is_digit, is_sep;
  logic [3:0]            digit;
  logic [VALUE_BITS+3:0] ext, tenx;
  logic                  would_ovf;

  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_sep   = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
                    (char_byte == CH_CR) || (char_byte == CH_LF) ||
                    (char_byte == CH_COMMA);
  assign digit    = char_byte[3:0];

  // acc*10 + d as shift-and-add; any bit above the value width means saturation
  assign ext       = {4'b0000, acc_r};
  assign tenx      = (ext << 3) + (ext << 1) + {{VALUE_BITS{1'b0}}, digit};
  assign would_ovf = |tenx[VALUE_BITS+3:VALUE_BITS];

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    sat_nxt     = sat_r;
    garbage_nxt = garbage_r;
    res         = '0;
    if (stream_end) begin
      res.valid = 1'b1;
      res.last  = 1'b1;
      if (phase_r == PH_NUMBER) begin
        res.value   = to_out(acc_r);
        res.present = 1'b1;
        res.ovf     = sat_r;
      end
      phase_nxt   = PH_SKIP;
      acc_nxt     = '0;
      sat_nxt     = 1'b0;
      garbage_nxt = 1'b0;
    end else begin
      case (phase_r)
        PH_COMMENT: begin
          if (char_byte == CH_LF) phase_nxt = PH_SKIP;
        end
        PH_NUMBER: begin
          if (is_digit) begin
            if (would_ovf) begin
              acc_nxt = VALUE_MAX;
              sat_nxt = 1'b1;
            end else begin
              acc_nxt = tenx[VALUE_BITS-1:0];
            end
          end else begin
            // emit and handle the ending byte as a byte between numbers
            res.valid   = 1'b1;
            res.value   = to_out(acc_r);
            res.present = 1'b1;
            res.ovf     = sat_r;
            phase_nxt   = PH_SKIP;
            acc_nxt     = '0;
            sat_nxt     = 1'b0;
            if (char_byte == CH_HASH) phase_nxt = PH_COMMENT;
            else if (!is_sep) garbage_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_SKIP;
          if (char_byte == CH_HASH) begin
            phase_nxt = PH_COMMENT;
          end else if (is_digit) begin
            if (!mode_r) begin
              acc_nxt   = {{(VALUE_BITS-4){1'b0}}, digit};
              sat_nxt   = 1'b0;
              phase_nxt = PH_NUMBER;
            end else if ((char_byte == CH_ZERO) || (char_byte == CH_ONE)) begin
              res.valid   = 1'b1;
              res.value   = {{(OUT_BITS-1){1'b0}}, char_byte[0]};
              res.present = 1'b1;
            end else begin
              garbage_nxt = 1'b1;
            end
          end else if (!is_sep) begin
            garbage_nxt = 1'b1;
          end
        end
      endcase
      res.garbage = garbage_nxt;
    end
    if (!stream_end) res.garbage = garbage_nxt;
    else res.garbage = garbage_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      phase_r   <= PH_SKIP;
      acc_r     <= '0;
      sat_r     <= 1'b0;
      garbage_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (step) begin
        phase_r   <= phase_nxt;
        acc_r     <= acc_nxt;
        sat_r     <= sat_nxt;
        garbage_r <= garbage_nxt;
      end
    end
  end

  `PNM_ASSERT_RST(a_sat_holds_max, clk, rst_n, sat_r |-> (acc_r == VALUE_MAX))
  `PNM_ASSERT_RST(a_idle_acc_clear, clk, rst_n,
                  (phase_r != PH_NUMBER) |-> ((acc_r == '0) && !sat_r))
  `PNM_ASSERT_RST(a_end_clears, clk, rst_n,
                  (step && stream_end) |=> ((phase_r == PH_SKIP) && !garbage_r))

endmodule
`default_nettype wire

/* rtl/pnm_tok_out_reg.sv */
// Result register: holds one finished result until the downstream side takes it.
// Depends on pnm_tok_pkg.
`default_nettype none
module pnm_tok_out_reg
  import pnm_tok_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire tok_res_t  res,
  output logic           space,
  output logic           out_valid,
  input  wire logic      out_ready,
  output tok_res_t       out_res
);

  logic     valid_r, valid_nxt;
  tok_res_t res_r;

  // room when empty or when the held result leaves this cycle
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load && res.valid) valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) res_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

/* rtl/pnm_ascii_number_tokenizer.sv */
// Top level of the ASCII portable-anymap number tokenizer.
// Depends on pnm_tok_pkg, pnm_tok_core and pnm_tok_out_reg.
//
//   channel  direction  fields (low bit first)
//   in_*     slave      tdata[7:0] char_byte, tlast stream_end
//   out_*    master     tdata[31:0] number_value, tuser[0] number_present,
//                       tuser[1] garbage_seen, tuser[2] overflowed, tlast last
//   cfg_*    write-only cfg_wr_data = digit_mode
//
// One byte per cycle while in_tready is high: every transfer is decoded in the
// same cycle by the core (one shift-and-add and compare for the times-ten step)
// and its result, if any, is captured in the output register.
// in_tready drops only while a held result is stalled by out_tready low.
// Reset is synchronous, active low; it clears state and the output valid.
`default_nettype none
module pnm_ascii_number_tokenizer
  import pnm_tok_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,  // digit_mode
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] char_byte
  input  wire logic        in_tlast,     // stream_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,    // [31:0] number_value
  output logic [2:0]       out_tuser,    // [0] number_present, [1] garbage_seen, [2] overflowed
  output logic             out_tlast     // last
);

  logic     in_xfer;
  logic     space;
  tok_res_t step_res;
  tok_res_t held_res;

  // accept whenever the result register can take what this byte produces
  assign in_tready = space;
  assign in_xfer   = in_tvalid && space;

  pnm_tok_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (in_xfer),
    .char_byte   (in_tdata),
    .stream_end  (in_tlast),
    .res         (step_res)
  );

  pnm_tok_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer),
    .res       (step_res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (held_res)
  );

  // unpack the held result onto the stream fields
  assign out_tdata = held_res.value;
  assign out_tuser = {held_res.ovf, held_res.garbage, held_res.present};
  assign out_tlast = held_res.last;

endmodule
`default_nettype wire
